@@ hdl/websocket_frame_deframer_top_macros.svh @@
// Assertion macros for the deframer port checker
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("wsfd check failed");

// Next-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("wsfd check failed");

`endif

@@ hdl/wsfd_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer
`timescale 1ns / 1ps

package wsfd_pkg;

  // Result kinds
  localparam logic [1:0] KindData      = 2'd0;
  localparam logic [1:0] KindPingByte  = 2'd1;
  localparam logic [1:0] KindEmptyPing = 2'd2;
  localparam logic [1:0] KindClose     = 2'd3;

  // Frame opcodes
  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'hA;

  // Length codes of the second header byte and the ping payload limit
  localparam logic [6:0]  Len7Ext16 = 7'd126;
  localparam logic [6:0]  Len7Ext64 = 7'd127;
  localparam logic [63:0] PingMax   = 64'd125;

  // Configuration port
  localparam int unsigned PAddrW = 3;
  localparam int unsigned PDataW = 32;
  localparam logic        RegWsMode = 1'b0;  // register index, paddr[2]

  // Parser phase
  typedef enum logic [7:0] {
    PhHdr0   = 8'b0000_0001,
    PhHdr1   = 8'b0000_0010,
    PhExt16  = 8'b0000_0100,
    PhExt64  = 8'b0000_1000,
    PhMask   = 8'b0001_0000,
    PhData   = 8'b0010_0000,
    PhSkip   = 8'b0100_0000,
    PhClosed = 8'b1000_0000
  } phase_e;

endpackage

@@ hdl/websocket_frame_deframer_top.sv @@
// WebSocket receive deframer: header parse, unmasking and control events
`timescale 1ns / 1ps

// Receive-side WebSocket deframer. Bytes arrive on the rx channel one per
// transfer. With ws_mode (APB register at byte address 0, bit 0) clear every
// byte leaves as a data byte. With ws_mode set the block parses client frame
// headers (opcode, mask bit, 7/16/64-bit big-endian length, 4-byte mask key)
// and emits binary and continuation payload unmasked, ping payloads of up to
// 125 bytes raw with ping_last on the final byte, an empty-ping event for a
// zero-length ping and a close event at the end of a close frame; after close
// every byte is dropped until reset. Pongs, oversized pings and unknown
// opcodes are consumed silently. Throughput is one byte per clock while the
// result side does not stall: a byte sits in the input register, and when it
// advances the parser state and the result register are updated from it; the
// result is then offered from the result register.
// The input register lets the next byte be taken while a result waits behind
// out_stall_i. Write ws_mode only while the block is idle.
module websocket_frame_deframer_top
  import wsfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  // Received byte channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,

  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        out_byte_o,
  output logic              ping_last_o,

  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [PDataW-1:0] pwdata,
  output logic [PDataW-1:0] prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic ws_mode_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegWsMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      ws_mode_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegWsMode) begin
      prdata[0] = ws_mode_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and handshake
  // ---------------------------------------------------------------------------
  logic       in_vq;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       out_vq;

  // The held byte is processed whenever the result register can take a result
  assign advance    = in_vq && (!out_vq || !out_stall_i);
  assign in_stall_o = in_vq && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vq <= 1'b1;
    end else if (advance) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_e      phase_q,  phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] len_q,    len_d;
  logic [2:0]  hcnt_q,   hcnt_d;
  logic [7:0]  key_q [4];
  logic [7:0]  key_d [4];
  logic [1:0]  midx_q,   midx_d;

  logic        emit;
  logic [1:0]  res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic        hdr_done;    // length known this byte
  logic        start;       // header complete, pick payload handling
  logic        len_last;    // payload byte is the final one
  logic        ext_last;

  assign len_last = (len_q == 64'd1);

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    masked_d = masked_q;
    len_d    = len_q;
    hcnt_d   = hcnt_q;
    key_d    = key_q;
    midx_d   = midx_q;
    emit     = 1'b0;
    res_kind = KindData;
    res_byte = 8'h00;
    res_last = 1'b0;
    hdr_done = 1'b0;
    start    = 1'b0;
    ext_last = 1'b0;

    if (!ws_mode_q) begin
      // passthrough leaves the parse untouched
      emit     = 1'b1;
      res_byte = in_byte_q;
    end else begin
      unique case (phase_q)
        PhHdr0: begin
          opcode_d = in_byte_q[3:0];
          phase_d  = PhHdr1;
        end
        PhHdr1: begin
          masked_d = in_byte_q[7];
          hcnt_d   = 3'd0;
          if (in_byte_q[6:0] == Len7Ext16) begin
            len_d   = '0;
            phase_d = PhExt16;
          end else if (in_byte_q[6:0] == Len7Ext64) begin
            len_d   = '0;
            phase_d = PhExt64;
          end else begin
            len_d    = {57'd0, in_byte_q[6:0]};
            hdr_done = 1'b1;
          end
        end
        PhExt16, PhExt64: begin
          len_d    = {len_q[55:0], in_byte_q};
          ext_last = (phase_q == PhExt16) ? (hcnt_q == 3'd1) : (hcnt_q == 3'd7);
          if (ext_last) begin
            hcnt_d   = 3'd0;
            hdr_done = 1'b1;
          end else begin
            hcnt_d = hcnt_q + 3'd1;
          end
        end
        PhMask: begin
          key_d[hcnt_q[1:0]] = in_byte_q;
          if (hcnt_q[1:0] == 2'd3) begin
            hcnt_d = 3'd0;
            midx_d = 2'd0;
            start  = 1'b1;
          end else begin
            hcnt_d = hcnt_q + 3'd1;
          end
        end
        PhData: begin
          len_d = len_q - 64'd1;
          if (len_last) begin
            phase_d = PhHdr0;
          end
          emit = 1'b1;
          if (opcode_q == OpPing) begin
            res_kind = KindPingByte;
            res_byte = in_byte_q;
            res_last = len_last;
          end else if (masked_q) begin
            res_byte = in_byte_q ^ key_q[midx_q];
            midx_d   = midx_q + 2'd1;
          end else begin
            res_byte = in_byte_q;
          end
        end
        PhSkip: begin
          len_d = len_q - 64'd1;
          if (len_last) begin
            if (opcode_q == OpClose) begin
              phase_d  = PhClosed;
              emit     = 1'b1;
              res_kind = KindClose;
            end else begin
              phase_d = PhHdr0;
            end
          end
        end
        PhClosed: begin
          // everything after a close is dropped
        end
        default: begin
        end
      endcase

      // length field finished: mask key next, or the payload directly
      if (hdr_done) begin
        if (masked_d) begin
          phase_d = PhMask;
          hcnt_d  = 3'd0;
        end else begin
          start = 1'b1;
        end
      end

      if (start) begin
        if (opcode_q == OpClose) begin
          if (len_d == '0) begin
            phase_d  = PhClosed;
            emit     = 1'b1;
            res_kind = KindClose;
          end else begin
            phase_d = PhSkip;
          end
        end else if (opcode_q == OpPing) begin
          if (len_d == '0) begin
            phase_d  = PhHdr0;
            emit     = 1'b1;
            res_kind = KindEmptyPing;
          end else begin
            phase_d = (len_d > PingMax) ? PhSkip : PhData;
          end
        end else if (len_d == '0) begin
          phase_d = PhHdr0;
        end else begin
          phase_d = (opcode_q == OpBin || opcode_q == OpCont) ? PhData : PhSkip;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      opcode_q <= 4'h0;
      masked_q <= 1'b0;
      len_q    <= '0;
      hcnt_q   <= 3'd0;
      key_q    <= '{default: 8'h00};
      midx_q   <= 2'd0;
    end else if (advance) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      hcnt_q   <= hcnt_d;
      key_q    <= key_d;
      midx_q   <= midx_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [1:0] out_kind_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (advance && emit) begin
      out_vq <= 1'b1;
    end else if (!out_stall_i) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_last_q <= res_last;
    end
  end

  assign out_valid_o = out_vq;
  assign kind_o      = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign ping_last_o = out_last_q;

endmodule

@@ hdl/wsfd_checker.sv @@
// Port-level checks for the WebSocket frame deframer, bound to the top level
`timescale 1ns / 1ps
`include "websocket_frame_deframer_top_macros.svh"

module wsfd_checker
  import wsfd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic       ping_last_o
);

  // a stalled result holds
  `WSFD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o) && $stable(out_byte_o) && $stable(ping_last_o))

  // events carry no byte and no pong request
  `WSFD_ASSERT_NOW(a_event_clean, clk_i, rst_ni, out_valid_o && (kind_o == KindEmptyPing || kind_o == KindClose), out_byte_o == 8'h00 && !ping_last_o)

  // ping_last only marks ping payload
  `WSFD_ASSERT_NOW(a_last_is_ping, clk_i, rst_ni, out_valid_o && ping_last_o, kind_o == KindPingByte)

  // data bytes never request a pong
  `WSFD_ASSERT_NOW(a_data_no_last, clk_i, rst_ni, out_valid_o && kind_o == KindData, !ping_last_o)

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .out_byte_o  (out_byte_o),
  .ping_last_o (ping_last_o)
);

@@ verif/websocket_frame_deframer_checker.sv @@
// Deframer checker: tracks ws_mode, predicts each result and compares on transfer
`timescale 1ns / 1ps

module websocket_frame_deframer_checker
  import wsfd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        out_byte_i,
  input  logic              ping_last_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [PAddrW-1:0] paddr_i,
  input  logic [PDataW-1:0] pwdata_i,
  output int unsigned       mismatches_o,
  output int unsigned       due_count_o
);

  localparam int unsigned MaxReports = 10;
  localparam logic [PAddrW-1:0] WsModeAddr = {RegWsMode, 2'b00};

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } ws_result_t;

  ws_result_t  deframed_due[$];

  // mirror of the register and of the parser
  logic        mode_ws;
  phase_e      parse_ph;
  logic [3:0]  hdr_op;
  logic        hdr_masked;
  logic [63:0] bytes_left;
  logic [2:0]  ext_cnt;
  logic [7:0]  key_byte[4];
  logic [1:0]  key_pos;

  // header complete: route the payload
  function automatic bit open_payload(output ws_result_t r);
    r = '0;
    if (hdr_op == OpClose) begin
      if (bytes_left == 0) begin
        parse_ph = PhClosed;
        r.kind   = KindClose;
        return 1'b1;
      end
      parse_ph = PhSkip;
      return 1'b0;
    end
    if (hdr_op == OpPing) begin
      if (bytes_left == 0) begin
        parse_ph = PhHdr0;
        r.kind   = KindEmptyPing;
        return 1'b1;
      end
      parse_ph = (bytes_left > PingMax) ? PhSkip : PhData;
      return 1'b0;
    end
    if (bytes_left == 0) parse_ph = PhHdr0;
    else parse_ph = (hdr_op == OpBin || hdr_op == OpCont) ? PhData : PhSkip;
    return 1'b0;
  endfunction

  function automatic bit length_known(output ws_result_t r);
    r = '0;
    if (hdr_masked) begin
      parse_ph = PhMask;
      ext_cnt  = '0;
      return 1'b0;
    end
    return open_payload(r);
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output ws_result_t r);
    logic [6:0] len7;
    r = '0;
    if (!mode_ws) begin
      r.kind = KindData;
      r.data = b;
      return 1'b1;
    end
    case (parse_ph)
      PhHdr0: begin
        hdr_op   = b[3:0];
        parse_ph = PhHdr1;
        return 1'b0;
      end
      PhHdr1: begin
        hdr_masked = b[7];
        len7       = b[6:0];
        ext_cnt    = '0;
        if (len7 == Len7Ext16 || len7 == Len7Ext64) begin
          bytes_left = '0;
          parse_ph   = (len7 == Len7Ext16) ? PhExt16 : PhExt64;
          return 1'b0;
        end
        bytes_left = 64'(len7);
        return length_known(r);
      end
      PhExt16, PhExt64: begin
        bytes_left = {bytes_left[55:0], b};
        if (ext_cnt == ((parse_ph == PhExt16) ? 3'd1 : 3'd7)) begin
          ext_cnt = '0;
          return length_known(r);
        end
        ext_cnt = ext_cnt + 3'd1;
        return 1'b0;
      end
      PhMask: begin
        key_byte[ext_cnt[1:0]] = b;
        if (ext_cnt[1:0] == 2'd3) begin
          ext_cnt = '0;
          key_pos = '0;
          return open_payload(r);
        end
        ext_cnt = ext_cnt + 3'd1;
        return 1'b0;
      end
      PhData: begin
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == 0) parse_ph = PhHdr0;
        if (hdr_op == OpPing) begin
          // ping payload goes out raw for the pong echo
          r.kind = KindPingByte;
          r.data = b;
          r.last = (bytes_left == 0);
          return 1'b1;
        end
        r.kind = KindData;
        r.data = b;
        if (hdr_masked) begin
          r.data  = b ^ key_byte[key_pos];
          key_pos = key_pos + 2'd1;
        end
        return 1'b1;
      end
      PhSkip: begin
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == 0) begin
          if (hdr_op == OpClose) begin
            parse_ph = PhClosed;
            r.kind   = KindClose;
            return 1'b1;
          end
          parse_ph = PhHdr0;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ws_result_t got;
    ws_result_t want;
    ws_result_t fresh;
    if (!rst_ni) begin
      mode_ws      = 1'b0;
      parse_ph     = PhHdr0;
      hdr_op       = '0;
      hdr_masked   = 1'b0;
      bytes_left   = '0;
      ext_cnt      = '0;
      key_pos      = '0;
      mismatches_o = 0;
      foreach (key_byte[i]) key_byte[i] = '0;
      deframed_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{kind: kind_i, data: out_byte_i, last: ping_last_i};
        if (deframed_due.size() == 0) begin
          if (mismatches_o < MaxReports)
            $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                     $realtime, got.kind, got.data, got.last);
          mismatches_o = mismatches_o + 1;
        end else begin
          want = deframed_due.pop_front();
          if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last) begin
            if (mismatches_o < MaxReports)
              $display("%0t: result mismatch exp kind=%0d byte=%02h last=%0b, got %0d %02h %0b",
                       $realtime, want.kind, want.data, want.last,
                       got.kind, got.data, got.last);
            mismatches_o = mismatches_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (deframe_byte(rx_byte_i, fresh)) deframed_due.push_back(fresh);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == WsModeAddr)
        mode_ws = pwdata_i[0];
    end
    due_count_o = deframed_due.size();
  end

endmodule

@@ verif/tb_websocket_frame_deframer_top.sv @@
// Testbench top for the WebSocket frame deframer: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_top;
  import wsfd_pkg::*;

  // Run limits; the watchdog limit is far above the slowest legal run.
  localparam int unsigned CycleLimit  = 200000;
  // a byte's result passes the input and result registers; allow a margin
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned LongHold    = 64;
  localparam int unsigned PhaseBytes  = 380;

  // ws_mode sits in register slot 0; the other slot of the 3-bit address
  // space holds nothing and writes to it must be ignored
  localparam logic [PAddrW-1:0] WsModeAddr    = {RegWsMode, 2'b00};
  localparam logic [PAddrW-1:0] UnusedRegAddr = {~RegWsMode, 2'b00};

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [1:0]        kind_o;
  logic [7:0]        out_byte_o;
  logic              ping_last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAddrW-1:0] paddr;
  logic [PDataW-1:0] pwdata;
  logic [PDataW-1:0] prdata;
  logic              pready;

  int unsigned mismatches;
  int unsigned due_count;
  int unsigned cycle_count = 0;
  int unsigned sent_bytes;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_left;
  bit          hold_ask;
  bit          hold_taken;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  websocket_frame_deframer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .out_byte_o (out_byte_o),
    .ping_last_o(ping_last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  websocket_frame_deframer_checker deframe_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_i      (kind_o),
    .out_byte_i  (out_byte_o),
    .ping_last_i (ping_last_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .mismatches_o(mismatches),
    .due_count_o (due_count)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver side. A long hold-off (hold_left, counted here) overrides the
  // random stalling so the block backs up and has to stall its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_ask && !hold_taken) begin
      out_stall_i <= 1'b1;
      hold_left   <= LongHold - 1;
      hold_taken  <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct);
    end
  end

  // One byte transfer. Idle cycles go in front at the sender's rate; the
  // byte is then held until the block takes it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Stop offering and wait until every predicted result has gone out.
  // The count is read at the falling edge, clear of the checker's update.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (due_count != 0);
    @(posedge clk_i);
  endtask

  // Quiet before a register write: bytes that give no result may still be
  // in flight after the last result, so let the pipe run dry as well.
  task automatic wait_idle();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle held until pready.
  task automatic apb_write(input logic [PAddrW-1:0] addr, input logic [PDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // A well-formed frame with random flags, random length encoding (short
  // lengths also go out in the 16- and 64-bit forms), optional mask key and
  // random payload.
  task automatic send_frame(input logic [3:0] op, input logic [63:0] len, input bit masked);
    int unsigned enc;
    enc = $urandom_range(0, 9);
    send_byte({4'($urandom), op});
    if (len < 64'(Len7Ext16) && enc < 7) begin
      send_byte({masked, len[6:0]});
    end else if (len <= 64'hFFFF && enc < 9) begin
      send_byte({masked, Len7Ext16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({masked, Len7Ext64});
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (masked) repeat (4) send_byte(8'($urandom));
    for (int unsigned i = 0; i < 32'(len); i++) send_byte(8'($urandom));
  endtask

  initial begin
    int unsigned quota;
    int unsigned pick;
    logic [3:0]  op;
    logic [63:0] len;
    bit          paused;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sent_bytes    = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_ask      = 1'b0;
    paused        = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // Passthrough out of reset; a write to the empty slot must not switch
    // the mode.
    apb_write(UnusedRegAddr, 1);
    send_bytes('{8'h00, 8'hFF});
    wait_idle();
    apb_write(WsModeAddr, 1);
    // masked continuation frame, two bytes, unmasked on the way out
    send_bytes('{8'h80, 8'h82, 8'h00, 8'hFF, 8'h5A, 8'hC3, 8'hFF, 8'h00});
    // zero-length binary gives nothing; zero-length ping gives the event
    send_bytes('{8'h82, 8'h00, 8'h89, 8'h00});
    // masked one-byte ping: payload must come out raw with ping_last
    send_bytes('{8'h89, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A});
    // ping header split by a passthrough interlude; the parse resumes after
    send_byte(8'h89);
    wait_idle();
    apb_write(WsModeAddr, 0);
    send_byte(8'h42);
    wait_idle();
    apb_write(WsModeAddr, 1);
    send_bytes('{8'h02, 8'h10, 8'h20});

    // ---- random part: three idling mixes ----
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  <= (ph == 0) ? 9 : (ph == 1) ? 48 : 0;
      snk_stall_pct <= (ph == 0) ? 48 : (ph == 1) ? 9 : 0;
      // back the block up while the sender keeps offering
      if (ph == 0) hold_ask <= 1'b1;
      quota = sent_bytes + PhaseBytes;
      while (sent_bytes < quota) begin
        pick = $urandom_range(0, 99);
        op   = OpBin;
        len  = 64'($urandom_range(1, 24));
        if (pick < 35) begin
          op = OpBin;
        end else if (pick < 55) begin
          op = OpCont;
        end else if (pick < 72) begin
          op  = OpPing;
          len = ($urandom_range(0, 9) == 0) ? PingMax : 64'($urandom_range(1, 12));
        end else if (pick < 78) begin
          // just past the ping limit and beyond: silently skipped
          op  = OpPing;
          len = PingMax + 64'($urandom_range(1, 80));
        end else if (pick < 85) begin
          op = OpPong;
        end else if (pick < 92) begin
          do op = 4'($urandom);
          while (op == OpCont || op == OpBin || op == OpClose || op == OpPing);
        end else begin
          // empty frame of any kind bar close
          do op = 4'($urandom); while (op == OpClose);
          len = '0;
        end
        if ((op == OpBin || op == OpCont) && $urandom_range(0, 19) == 0)
          len = 64'($urandom_range(126, 300));
        send_frame(op, len, 1'($urandom));
        // once, let the sender sit until every result is out
        if (ph == 1 && !paused && sent_bytes + PhaseBytes / 2 > quota) begin
          wait_drained();
          paused = 1'b1;
        end
      end
      // passthrough interlude, then back to framing
      wait_idle();
      apb_write(WsModeAddr, 0);
      repeat (15) send_byte(8'($urandom));
      wait_idle();
      apb_write(WsModeAddr, 1);
    end

    // ---- close: terminal for the parser, so it comes last ----
    pick = $urandom_range(0, 2);
    len  = (pick == 0) ? 64'd0 : (pick == 1) ? 64'($urandom_range(1, 10))
                                             : 64'($urandom_range(126, 200));
    send_frame(OpClose, len, 1'($urandom));
    // everything after the close is dropped in framing mode...
    repeat (12) send_byte(8'($urandom));
    wait_idle();
    // ...but passthrough still works
    apb_write(WsModeAddr, 0);
    repeat (10) send_byte(8'($urandom));

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && due_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/wsfd_pkg.sv
hdl/websocket_frame_deframer_top.sv
hdl/wsfd_checker.sv
verif/websocket_frame_deframer_checker.sv
verif/tb_websocket_frame_deframer_top.sv
